@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication under an active-low reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

@@ rtl/icdf_pkg.sv @@
// ----------------------------------------------------------------------------
// icdf_pkg
// Types, widths and constants of the inverse-CDF table sampler.
// ----------------------------------------------------------------------------
package icdf_pkg;

  localparam int unsigned TABLE_DEPTH_DEFAULT = 4096;
  localparam int unsigned CFG_W      = 13;
  localparam int unsigned IDX_W      = 12;
  localparam int unsigned CDF_W      = 32;
  localparam int unsigned LOG_W      = 20;
  localparam int unsigned ENERGY_W   = 22;
  localparam int unsigned FRAC_STEPS = 16;
  localparam int unsigned ACC_W      = 32;
  localparam int unsigned KW         = 31;
  localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;
  localparam logic [CFG_W-1:0]    CFG_RESET  = 13'd4096;

  typedef enum logic [1:0] {
    STAT_LOADED      = 2'd0,
    STAT_INTERP      = 2'd1,
    STAT_CLAMP_FIRST = 2'd2,
    STAT_CLAMP_LAST  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_DIV,
    S_MUL,
    S_SUM,
    S_EXP,
    S_OUT
  } state_e;

  typedef logic [FRAC_STEPS:0][KW-1:0] root_tab_t;

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    logic [63:0] rem;
    res  = '0;
    bitv = 64'd1 << 62;
    rem  = n;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // k_j = 2^(2^-j) in Q1.30; entry 0 unused
  function automatic root_tab_t root_table();
    root_tab_t   t;
    logic [63:0] k;
    t = '0;
    k = 64'd1 << 31;
    for (int j = 1; j <= FRAC_STEPS; j++) begin
      k    = int_sqrt(k << 30);
      t[j] = k[KW-1:0];
    end
    return t;
  endfunction

endpackage

@@ rtl/icdf_if.sv @@
// ----------------------------------------------------------------------------
// icdf channel interfaces
// Valid/ready channels for sampler items and results.
// ----------------------------------------------------------------------------
interface icdf_in_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [icdf_pkg::IDX_W-1:0]    entry_index;
  logic [icdf_pkg::CDF_W-1:0]    cdf_value;
  logic [icdf_pkg::LOG_W-1:0]    log_energy;
  logic [icdf_pkg::CDF_W-1:0]    uniform_sample;

  modport source (output valid, command, entry_index, cdf_value, log_energy,
                  uniform_sample, input ready);
  modport sink (input valid, command, entry_index, cdf_value, log_energy,
                uniform_sample, output ready);
  modport monitor (input valid, ready, command, entry_index, cdf_value, log_energy,
                   uniform_sample);
endinterface

interface icdf_out_if;
  logic                          valid;
  logic                          ready;
  logic [icdf_pkg::ENERGY_W-1:0] energy;
  logic [icdf_pkg::IDX_W-1:0]    bin_upper;
  logic [1:0]                    status;

  modport source (output valid, energy, bin_upper, status, input ready);
  modport sink (input valid, energy, bin_upper, status, output ready);
  modport monitor (input valid, ready, energy, bin_upper, status);
endinterface

@@ rtl/icdf_ram.sv @@
// ----------------------------------------------------------------------------
// icdf_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module icdf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/icdf_div.sv @@
// ----------------------------------------------------------------------------
// icdf_div
// Restoring divider for the bin fraction, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module icdf_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [icdf_pkg::CDF_W-1:0] num_i,
  input  logic [icdf_pkg::CDF_W-1:0] den_i,
  output logic                       done_o,
  output logic [icdf_pkg::CDF_W:0]   quot_o
);

  localparam int unsigned W = icdf_pkg::CDF_W;

  logic [5:0]   cnt_q, cnt_d;
  logic         busy_q, busy_d;
  logic         first_q, first_d;
  logic         done_q, done_d;
  logic [W-1:0] rem_q, rem_d;
  logic [W-1:0] den_q, den_d;
  logic [W:0]   quot_q, quot_d;
  logic [W:0]   trial;
  logic         ge;

  always_comb begin
    trial   = first_q ? {1'b0, rem_q} : {rem_q, 1'b0};
    ge      = trial >= {1'b0, den_q};
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    first_d = first_q;
    done_d  = 1'b0;
    rem_d   = rem_q;
    den_d   = den_q;
    quot_d  = quot_q;
    if (start_i) begin
      busy_d  = 1'b1;
      first_d = 1'b1;
      cnt_d   = 6'(W);
      rem_d   = num_i;
      den_d   = den_i;
      quot_d  = '0;
    end else if (busy_q) begin
      first_d = 1'b0;
      rem_d   = ge ? W'(trial - {1'b0, den_q}) : W'(trial);
      quot_d  = {quot_q[W-1:0], ge};
      cnt_d   = cnt_q - 6'd1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q   <= cnt_d;
    first_q <= first_d;
    rem_q   <= rem_d;
    den_q   <= den_d;
    quot_q  <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

@@ rtl/icdf_exp2.sv @@
// ----------------------------------------------------------------------------
// icdf_exp2
// Iterative 2^x: one root-constant multiply per fraction bit, then scale.
// ----------------------------------------------------------------------------
module icdf_exp2 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [icdf_pkg::LOG_W-1:0]    x_i,
  output logic                          done_o,
  output logic [icdf_pkg::ENERGY_W-1:0] energy_o
);

  localparam int unsigned AW = icdf_pkg::ACC_W;
  localparam int unsigned KW = icdf_pkg::KW;
  localparam int unsigned NF = icdf_pkg::FRAC_STEPS;
  localparam int unsigned LOG_W_HI = icdf_pkg::LOG_W - 1;
  localparam icdf_pkg::root_tab_t KTAB = icdf_pkg::root_table();

  logic [4:0]          j_q, j_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [3:0]          ip_q, ip_d;
  logic [NF-1:0]       fb_q, fb_d;
  logic [AW-1:0]       acc_q, acc_d;
  logic [icdf_pkg::ENERGY_W-1:0] en_q, en_d;
  logic [AW+KW-1:0]    prod;
  logic [AW+KW-1:0]    rnd;
  logic [4:0]          sh;
  logic [AW:0]         scaled;

  always_comb begin
    prod   = acc_q * KTAB[j_q[3:0] == 4'd0 ? 5'(NF) : j_q];
    rnd    = prod + (AW+KW)'(64'd1 << 29);
    sh     = 5'd22 - 5'(ip_q);
    scaled = ({1'b0, acc_q} + ((AW+1)'(1) << (sh - 5'd1))) >> sh;
    j_d    = j_q;
    busy_d = busy_q;
    done_d = 1'b0;
    ip_d   = ip_q;
    fb_d   = fb_q;
    acc_d  = acc_q;
    en_d   = en_q;
    if (start_i) begin
      busy_d = 1'b1;
      j_d    = 5'd1;
      ip_d   = x_i[LOG_W_HI:NF];
      fb_d   = x_i[NF-1:0];
      acc_d  = AW'(1) << 30;
    end else if (busy_q) begin
      if (j_q == 5'(NF + 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        en_d   = (scaled > (AW+1)'(icdf_pkg::ENERGY_MAX)) ? icdf_pkg::ENERGY_MAX
                                                         : scaled[icdf_pkg::ENERGY_W-1:0];
      end else begin
        if (fb_q[NF-1]) begin
          acc_d = rnd[AW+29:30];
        end
        fb_d = {fb_q[NF-2:0], 1'b0};
        j_d  = j_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q   <= j_d;
    ip_q  <= ip_d;
    fb_q  <= fb_d;
    acc_q <= acc_d;
    en_q  <= en_d;
  end

  assign done_o   = done_q;
  assign energy_o = en_q;

endmodule

@@ rtl/inverse_cdf_table_sampler.sv @@
// ----------------------------------------------------------------------------
// inverse_cdf_table_sampler
// Tabulated inverse-CDF energy sampler with a first-match table scan.
// ----------------------------------------------------------------------------
// Items arrive on in_if (valid/ready); each gives exactly one result on
// out_if. A load item (command 0) writes one table entry and its result
// (status loaded, energy 0) is shown in the cycle after the transfer.
// A sample item scans the table from entry 0, one entry per READ and CMP
// state pair (single read port of the table RAM), up to the first entry
// whose cdf is not below the sample or the last entry in use. An interior
// hit then runs the divider (skipped for a flat bin), the multiply and sum
// states and the 2^x unit; a clamp goes straight to the 2^x unit.
// One item is in flight at a time: in_if.ready is high only while the
// block is idle. The result is held on out_if until transferred; the
// block takes no new item while the receiver stalls. entries_in_use is
// written by cfg_we_i and resets to 4096; the user must write it only
// while idle, and the block itself leaves this unchecked. Reset clears
// control state only; table entries are undefined until loaded.
// ----------------------------------------------------------------------------
module inverse_cdf_table_sampler #(
  parameter int unsigned TABLE_DEPTH = icdf_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [icdf_pkg::CFG_W-1:0] cfg_wdata_i,
  icdf_in_if.sink                    in_if,
  icdf_out_if.source                 out_if
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned NW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CW = icdf_pkg::CDF_W;
  localparam int unsigned LW = icdf_pkg::LOG_W;
  localparam int unsigned RW = CW + LW;
  localparam int unsigned PW = CW + 1 + LW;

  icdf_pkg::state_e  state_q, state_d;
  icdf_pkg::status_e status_q;

  logic [icdf_pkg::CFG_W-1:0]    cfg_q;
  logic [AW-1:0]                 ptr_q;
  logic [NW-1:0]                 n_q;
  logic [CW-1:0]                 u_q;
  logic [CW-1:0]                 c1_q;
  logic [LW-1:0]                 l1_q, l2_q;
  logic [CW:0]                   frac_q;
  logic [PW-1:0]                 prod_q;
  logic [icdf_pkg::ENERGY_W-1:0] energy_q;
  logic [icdf_pkg::IDX_W-1:0]    bin_q;

  logic          accept;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [RW-1:0] ram_rdata;
  logic [CW-1:0] cdf_rd;
  logic [LW-1:0] log_rd;
  logic          hit, at_first, at_last;
  logic [CW-1:0] den;
  logic          div_start, div_done;
  logic [CW:0]   div_quot;
  logic          exp_start, exp_done;
  logic [LW-1:0] exp_x;
  logic [icdf_pkg::ENERGY_W-1:0] exp_energy;
  logic          up;
  logic [LW-1:0] delta;
  logic [PW-1:0] rsum;
  logic [LW-1:0] x_sum;
  logic [31:0]   cfg_ext;
  logic [NW-1:0] n_clamped;

  assign accept    = in_if.valid & in_if.ready;
  assign cdf_rd    = ram_rdata[RW-1:LW];
  assign log_rd    = ram_rdata[LW-1:0];
  assign hit       = cdf_rd >= u_q;
  assign at_first  = ptr_q == '0;
  assign at_last   = NW'(ptr_q) == n_q - NW'(1);
  assign den       = cdf_rd - c1_q;
  assign ram_we    = accept & ~in_if.command
                     & (32'(in_if.entry_index) < 32'(TABLE_DEPTH));
  assign ram_waddr = AW'(in_if.entry_index);
  assign up        = l2_q >= l1_q;
  assign delta     = up ? l2_q - l1_q : l1_q - l2_q;
  assign rsum      = prod_q + PW'(64'd1 << 31);
  assign x_sum     = up ? l1_q + rsum[CW+LW-1:CW] : l1_q - rsum[CW+LW-1:CW];
  assign exp_x     = (state_q == icdf_pkg::S_CMP) ? log_rd : x_sum;
  assign cfg_ext   = 32'(cfg_q);

  always_comb begin
    if (cfg_ext < 32'd2) begin
      n_clamped = NW'(2);
    end else if (cfg_ext > 32'(TABLE_DEPTH)) begin
      n_clamped = NW'(TABLE_DEPTH);
    end else begin
      n_clamped = NW'(cfg_q);
    end
  end

  icdf_ram #(.WIDTH(RW), .DEPTH(TABLE_DEPTH)) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({in_if.cdf_value, in_if.log_energy}),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  icdf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (u_q - c1_q),
    .den_i   (den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  icdf_exp2 u_exp2 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (exp_start),
    .x_i      (exp_x),
    .done_o   (exp_done),
    .energy_o (exp_energy)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      icdf_pkg::S_IDLE: begin
        if (accept) begin
          state_d = in_if.command ? icdf_pkg::S_READ : icdf_pkg::S_OUT;
        end
      end
      icdf_pkg::S_READ: state_d = icdf_pkg::S_CMP;
      icdf_pkg::S_CMP: begin
        if (hit && !at_first) begin
          state_d = (den == '0) ? icdf_pkg::S_MUL : icdf_pkg::S_DIV;
        end else if (hit || at_last) begin
          state_d = icdf_pkg::S_EXP;
        end else begin
          state_d = icdf_pkg::S_READ;
        end
      end
      icdf_pkg::S_DIV: begin
        if (div_done) begin
          state_d = icdf_pkg::S_MUL;
        end
      end
      icdf_pkg::S_MUL: state_d = icdf_pkg::S_SUM;
      icdf_pkg::S_SUM: state_d = icdf_pkg::S_EXP;
      icdf_pkg::S_EXP: begin
        if (exp_done) begin
          state_d = icdf_pkg::S_OUT;
        end
      end
      icdf_pkg::S_OUT: begin
        if (out_if.ready) begin
          state_d = icdf_pkg::S_IDLE;
        end
      end
      default: state_d = icdf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_if.ready  = state_q == icdf_pkg::S_IDLE;
    out_if.valid = state_q == icdf_pkg::S_OUT;
    div_start    = (state_q == icdf_pkg::S_CMP) && hit && !at_first && (den != '0);
    exp_start    = ((state_q == icdf_pkg::S_CMP) && (hit ? at_first : at_last))
                   || (state_q == icdf_pkg::S_SUM);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= icdf_pkg::S_IDLE;
      cfg_q   <= icdf_pkg::CFG_RESET;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      icdf_pkg::S_IDLE: begin
        if (accept) begin
          u_q      <= in_if.uniform_sample;
          ptr_q    <= '0;
          n_q      <= n_clamped;
          energy_q <= '0;
          bin_q    <= in_if.entry_index;
          status_q <= icdf_pkg::STAT_LOADED;
        end
      end
      icdf_pkg::S_CMP: begin
        bin_q <= icdf_pkg::IDX_W'(ptr_q);
        if (hit && !at_first) begin
          status_q <= icdf_pkg::STAT_INTERP;
          l2_q     <= log_rd;
          frac_q   <= '0;
        end else if (hit) begin
          status_q <= icdf_pkg::STAT_CLAMP_FIRST;
        end else if (at_last) begin
          status_q <= icdf_pkg::STAT_CLAMP_LAST;
        end else begin
          c1_q  <= cdf_rd;
          l1_q  <= log_rd;
          ptr_q <= ptr_q + AW'(1);
        end
      end
      icdf_pkg::S_DIV: begin
        if (div_done) begin
          frac_q <= div_quot;
        end
      end
      icdf_pkg::S_MUL: prod_q <= frac_q * delta;
      icdf_pkg::S_EXP: begin
        if (exp_done) begin
          energy_q <= exp_energy;
        end
      end
      default: ;
    endcase
  end

  assign out_if.energy    = energy_q;
  assign out_if.bin_upper = bin_q;
  assign out_if.status    = status_q;

endmodule

@@ rtl/icdf_checker.sv @@
// ----------------------------------------------------------------------------
// icdf_checker
// Port-level checks of the sampler, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module icdf_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [icdf_pkg::ENERGY_W-1:0] out_energy_i,
  input logic [1:0]                    out_status_i
);

  `ASSERT_NEXT(a_hold_result, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_energy_i) && $stable(out_status_i))
  `ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)
  `ASSERT_IMPL(a_one_in_flight, clk_i, rst_ni, out_valid_i, !in_ready_i)
  `ASSERT_IMPL(a_load_zero, clk_i, rst_ni, out_valid_i && (out_status_i == icdf_pkg::STAT_LOADED), out_energy_i == '0)

endmodule

bind inverse_cdf_table_sampler icdf_checker u_icdf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_if.valid),
  .in_ready_i   (in_if.ready),
  .out_valid_i  (out_if.valid),
  .out_ready_i  (out_if.ready),
  .out_energy_i (out_if.energy),
  .out_status_i (out_if.status)
);

@@ tb/icdf_test_if.sv @@
// ----------------------------------------------------------------------------
// Sampler test channels
// Keeps the channel interfaces compiled next to the bench.
// ----------------------------------------------------------------------------
// The channel interfaces come from rtl/icdf_if.sv. This file declares
// nothing, so that the same interfaces are not declared a second time.

@@ tb/inverse_cdf_table_sampler_test.sv @@
// ----------------------------------------------------------------------------
// Inverse-CDF table sampler test
// Loads the table, draws samples under random flow control and checks every
// result, field by field, against a local model of the search and the
// interpolation.
// ----------------------------------------------------------------------------
module inverse_cdf_table_sampler_test;
  timeunit 1ns;
  timeprecision 1ps;
  import icdf_pkg::*;

  typedef struct packed {
    logic [ENERGY_W-1:0] energy;
    logic [IDX_W-1:0]    bin_upper;
    status_e             status;
  } sample_result_t;

  localparam int FILL_N = 256;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  icdf_in_if  in_ch ();
  icdf_out_if out_ch ();

  inverse_cdf_table_sampler DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (in_ch.sink),
    .out_if     (out_ch.source)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  logic [CDF_W-1:0]    cdf_mirror [TABLE_DEPTH_DEFAULT];
  logic [LOG_W-1:0]    log_mirror [TABLE_DEPTH_DEFAULT];
  logic [CFG_W-1:0]    entries_cfg = CFG_RESET;
  longint unsigned     root_k [0:FRAC_STEPS];
  sample_result_t      pending_results [$];
  int errors = 0;
  int loads_sent = 0;
  int samples_sent = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  int hold_cycles = 0;
  bit sender_steady = 0;
  bit receiver_steady = 0;

  function automatic longint unsigned isqrt64(longint unsigned n);
    longint unsigned r;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= n) r = r | (64'd1 << b);
    end
    return r;
  endfunction

  function automatic logic [ENERGY_W-1:0] exp2_energy(logic [LOG_W-1:0] x);
    longint unsigned acc;
    longint unsigned e;
    int sh;
    acc = 64'd1 << 30;
    for (int j = 1; j <= FRAC_STEPS; j++) begin
      if (x[16-j]) acc = (acc * root_k[j] + (64'd1 << 29)) >> 30;
    end
    sh = 22 - int'(x[19:16]);
    e = (acc + (64'd1 << (sh - 1))) >> sh;
    return (e > 64'(ENERGY_MAX)) ? ENERGY_MAX : e[ENERGY_W-1:0];
  endfunction

  function automatic sample_result_t predict_sample(logic [CDF_W-1:0] u);
    sample_result_t r;
    int n;
    int hi;
    longint unsigned c1, c2, l1, l2, frac, mag;
    logic [LOG_W-1:0] x;
    n = int'(entries_cfg);
    if (n < 2) n = 2;
    if (n > TABLE_DEPTH_DEFAULT) n = TABLE_DEPTH_DEFAULT;
    hi = 0;
    while (hi < n && cdf_mirror[hi] < u) hi++;
    if (hi == 0) begin
      r.energy = exp2_energy(log_mirror[0]);
      r.bin_upper = '0;
      r.status = STAT_CLAMP_FIRST;
    end else if (hi == n) begin
      r.energy = exp2_energy(log_mirror[n-1]);
      r.bin_upper = IDX_W'(n - 1);
      r.status = STAT_CLAMP_LAST;
    end else begin
      c1 = cdf_mirror[hi-1];
      c2 = cdf_mirror[hi];
      l1 = log_mirror[hi-1];
      l2 = log_mirror[hi];
      frac = 0;
      if (c2 > c1 && u >= c1) frac = ((64'(u) - c1) << 32) / (c2 - c1);
      if (frac > (64'd1 << 32)) frac = 64'd1 << 32;
      if (l2 >= l1) begin
        mag = (frac * (l2 - l1) + (64'd1 << 31)) >> 32;
        x = LOG_W'(l1 + mag);
      end else begin
        mag = (frac * (l1 - l2) + (64'd1 << 31)) >> 32;
        x = LOG_W'(l1 - mag);
      end
      r.energy = exp2_energy(x);
      r.bin_upper = IDX_W'(hi);
      r.status = STAT_INTERP;
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(bit cmd, logic [IDX_W-1:0] idx, logic [CDF_W-1:0] cdf,
                           logic [LOG_W-1:0] le, logic [CDF_W-1:0] u);
    sample_result_t r;
    int gap;
    in_ch.command <= cmd;
    in_ch.entry_index <= idx;
    in_ch.cdf_value <= cdf;
    in_ch.log_energy <= le;
    in_ch.uniform_sample <= u;
    in_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    if (!cmd) begin
      cdf_mirror[idx] = cdf;
      log_mirror[idx] = le;
      r.energy = '0;
      r.bin_upper = idx;
      r.status = STAT_LOADED;
      loads_sent++;
    end else begin
      r = predict_sample(u);
      samples_sent++;
    end
    pending_results.push_back(r);
    gap = sender_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic load_entry(int idx, logic [CDF_W-1:0] cdf, logic [LOG_W-1:0] le);
    send_item(1'b0, IDX_W'(idx), cdf, le, $urandom);
  endtask

  task automatic draw(logic [CDF_W-1:0] u);
    send_item(1'b1, IDX_W'($urandom), $urandom, LOG_W'($urandom_range(0, 917504)), u);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_entries(logic [CFG_W-1:0] v);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    entries_cfg = v;
    cfg_we_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result energy=%0d bin=%0d status=%0d", $time,
                   out_ch.energy, out_ch.bin_upper, out_ch.status);
          errors++;
        end else begin
          sample_result_t e;
          e = pending_results.pop_front();
          status_seen[e.status]++;
          if (out_ch.energy !== e.energy) begin
            $display("%0t: energy expected %0d actual %0d", $time, e.energy, out_ch.energy);
            errors++;
          end
          if (out_ch.bin_upper !== e.bin_upper) begin
            $display("%0t: bin_upper expected %0d actual %0d", $time, e.bin_upper,
                     out_ch.bin_upper);
            errors++;
          end
          if (out_ch.status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, out_ch.status);
            errors++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else if (receiver_steady) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= (pick_gap() == 0);
      end
    end
  end

  // the top entry holds the largest cdf so that no search runs past the loaded part
  task automatic test_fill_table();
    for (int i = 0; i < FILL_N; i++)
      load_entry(i, (i == FILL_N - 1) ? '1
                    : ((CDF_W'(i) << 24) | CDF_W'($urandom_range(0, 24'hFFFFFF))),
                 LOG_W'(i * 3584));
  endtask

  task automatic test_full_depth();
    draw('0);
    draw('1);
    draw($urandom);
    draw(cdf_mirror[FILL_N-2]);
    set_entries(CFG_W'(FILL_N - 1));
    draw('1);
    set_entries(13'd8191);
    draw('1);
    set_entries(13'd0);
    draw('1);
    draw($urandom);
    set_entries(13'd1);
    draw(cdf_mirror[1]);
    draw('1);
  endtask

  task automatic test_edge_cases();
    set_entries(13'd4);
    load_entry(0, 32'd100, LOG_W'(917504));
    load_entry(1, 32'd100, '0);
    load_entry(2, 32'h8000_0000, LOG_W'(917504));
    load_entry(3, 32'hFFFF_FFFE, LOG_W'(3 << 16));
    draw('0);
    draw(32'd100);
    draw(32'd101);
    draw(32'h4000_0000);
    draw(32'h8000_0000);
    draw(32'h9000_0000);
    draw(32'hFFFF_FFFE);
    draw('1);
    load_entry(1, 32'h7000_0000, LOG_W'(65535));
    draw(32'h6000_0000);
    draw(32'h7800_0000);
  endtask

  task automatic test_random_phases();
    logic [CDF_W-1:0] cdfs [$];
    int n;
    int kind;
    logic [CDF_W-1:0] u;
    for (int p = 0; p < 14; p++) begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 6) : $urandom_range(2, 48);
      set_entries(CFG_W'(n));
      sender_steady = (p % 4 == 1);
      receiver_steady = (p % 4 == 2);
      cdfs.delete();
      for (int i = 0; i < n; i++) begin
        if (i > 0 && $urandom_range(0, 7) == 0) cdfs.push_back(cdfs[i-1]);
        else cdfs.push_back($urandom);
      end
      if (p % 5 != 4) cdfs.sort();
      for (int i = 0; i < n; i++)
        load_entry(i, cdfs[i], LOG_W'($urandom_range(0, 917504)));
      for (int k = 0; k < 80; k++) begin
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
          load_entry($urandom_range(0, n + 4), $urandom, LOG_W'($urandom_range(0, 917504)));
        end else begin
          case (kind)
            1: u = cdf_mirror[$urandom_range(0, n - 1)];
            2: u = cdf_mirror[$urandom_range(0, n - 1)] + 1;
            3: u = ($urandom_range(0, 1) == 1) ? '1 : '0;
            default: u = $urandom;
          endcase
          draw(u);
        end
      end
    end
    sender_steady = 0;
    receiver_steady = 0;
  endtask

  task automatic test_backpressure();
    set_entries(13'd16);
    hold_cycles = 400;
    for (int i = 0; i < 20; i++) draw($urandom);
    wait_idle();
    for (int i = 0; i < 10; i++) draw($urandom);
    set_entries(13'd4096);
    for (int i = 0; i < 3; i++) draw(32'h0010_0000 + $urandom_range(0, 32'h0100_0000));
  endtask

  initial begin
    for (int j = 0; j <= FRAC_STEPS; j++)
      root_k[j] = (j == 0) ? (64'd1 << 31) : isqrt64(root_k[j-1] << 30);
    in_ch.valid = 1'b0;
    in_ch.command = 1'b0;
    in_ch.entry_index = '0;
    in_ch.cdf_value = '0;
    in_ch.log_energy = '0;
    in_ch.uniform_sample = '0;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fill_table();
    test_full_depth();
    test_edge_cases();
    test_random_phases();
    test_backpressure();
    wait_idle();
    repeat (20) @(posedge clk_i);
    $display("run: %0d loads, %0d samples; interpolated %0d, first clamps %0d, last clamps %0d",
             loads_sent, samples_sent, status_seen[STAT_INTERP],
             status_seen[STAT_CLAMP_FIRST], status_seen[STAT_CLAMP_LAST]);
    $display("run: entry counts from 2 to the register maximum, flat and falling bins, long receiver stall");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("tb: failure");
    $finish;
  end

endmodule
